FILE: rtl/core/modulated_delay_chorus_defines.svh
// Assertion macros for the modulated delay chorus block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MODULATED_DELAY_CHORUS_DEFINES_SVH
`define MODULATED_DELAY_CHORUS_DEFINES_SVH

// Same-cycle implication under the active-low reset.
`define MDC_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under the active-low reset.
`define MDC_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mdc_pkg.sv
// Package for the modulated delay chorus: config codes, beat type, sine ROM, saturation.
// No dependencies.
package mdc_pkg;

  localparam int SINE_ENTRIES = 256;
  localparam int SINE_BITS = 8;

  localparam logic [2:0] CFG_PHASE_STEP = 3'd0;
  localparam logic [2:0] CFG_DEPTH_GAIN = 3'd1;
  localparam logic [2:0] CFG_FB_GAIN    = 3'd2;
  localparam logic [2:0] CFG_WET_MIX    = 3'd3;
  localparam logic [2:0] CFG_MIN_DELAY  = 3'd4;
  localparam logic [2:0] CFG_DELAY_SPAN = 3'd5;

  typedef struct packed {
    logic [23:0] phase_step;
    logic [15:0] depth_gain;
    logic [14:0] feedback_gain;
    logic [15:0] wet_mix;
    logic [19:0] min_delay;
    logic [19:0] delay_span;
  } mdc_cfg_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] sample;
  } mdc_beat_t;

  typedef logic [15:0] sine_rom_t [SINE_ENTRIES];

  function automatic sine_rom_t sine_rom_build();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      v;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      x = (64'd1686629713 * 64'(2 * k + 1)) / 64'(2 * SINE_ENTRIES);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum = sum - longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      v = longint'((64'(sum) * 64'd32767 + 64'd536870912) >> 30);
      if (v > 32767) begin
        v = 32767;
      end
      rom[k] = 16'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = sine_rom_build();

  function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
    logic signed [15:0] r;
    if (v > 25'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -25'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/mdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mdc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/mdc_queue.sv
// Front part: accepts input beats into a two-entry queue ahead of the engine.
// Depends on mdc_pkg.
module mdc_queue
  import mdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] sample_in_i,
  output mdc_beat_t          head_o,
  input  logic               pop_i
);

  logic signed [15:0] buf_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign pop = pop_i && (cnt_q != 2'd0);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.sample = buf_q[rd_q];

  always_comb begin
    wr_d = push ? ~wr_q : wr_q;
    rd_d = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= sample_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/core/mdc_engine.sv
// Back part: LFO, delay write, interpolated tap read, feedback and mix on one shared multiplier.
// Depends on mdc_pkg, mdc_ram and modulated_delay_chorus_defines.svh.
`include "modulated_delay_chorus_defines.svh"
module mdc_engine
  import mdc_pkg::*;
#(
  parameter int DELAY_DEPTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mdc_cfg_t           cfg_i,
  input  mdc_beat_t          head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_out_o
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int CW = AW + 1;
  localparam int DW = (AW + 9 > 22) ? AW + 9 : 22;
  localparam logic [DW-1:0] DMAX = DW'((DELAY_DEPTH - 1) * 256);
  localparam logic [DW-1:0] DMIN = DW'(256);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WR   = 4'd1;
  localparam logic [3:0] S_OFF  = 4'd2;
  localparam logic [3:0] S_DLY  = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_M0   = 4'd5;
  localparam logic [3:0] S_M1   = 4'd6;
  localparam logic [3:0] S_TAP  = 4'd7;
  localparam logic [3:0] S_FB   = 4'd8;
  localparam logic [3:0] S_MIX  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0]         state_q, state_d;
  logic signed [15:0] x_q, fb_q, old_q, new_q, tap_q, out_q;
  logic [31:0]        phase_q;
  logic [AW-1:0]      wi_q, cur_q;
  logic [CW-1:0]      cnt_q;
  logic [7:0]         frac_q;
  logic signed [39:0] m_q, m_d;
  logic               out_vld_q;

  logic [16:0]        depth_c, wet_c;
  logic [14:0]        fbg_c;
  logic [SINE_BITS-1:0] sidx;
  logic [15:0]        srom;
  logic signed [15:0] sine_c;
  logic [16:0]        off_c;
  logic [DW-1:0]      d_c, dcl_c;
  logic [AW-1:0]      dint_c, cur_c, nxt_c, raddr_c;
  logic [7:0]         dfrac_c, frac_c;
  logic [AW+1:0]      diff_c;
  logic signed [15:0] tap_c, rdata_c;
  logic signed [21:0] mul_a;
  logic signed [17:0] mul_b;
  logic               acc;
  logic               we_c;
  logic [AW-1:0]      wi_next;
  logic               ok_c;
  logic               out_load;
  logic [15:0]        wdata_c;

  assign depth_c = (cfg_i.depth_gain > 16'd32768) ? 17'd32768 : {1'b0, cfg_i.depth_gain};
  assign wet_c = (cfg_i.wet_mix > 16'd32768) ? 17'd32768 : {1'b0, cfg_i.wet_mix};
  assign fbg_c = (cfg_i.feedback_gain > 15'd32112) ? 15'd32112 : cfg_i.feedback_gain;

  assign sidx = phase_q[29:30-SINE_BITS] ^ {SINE_BITS{phase_q[30]}};
  assign srom = SINE_ROM[sidx];
  assign sine_c = phase_q[31] ? -$signed(srom) : $signed(srom);

  assign off_c = m_q[31:15] + 17'd32768;
  assign d_c = DW'(cfg_i.min_delay) + DW'(m_q[36:16]);
  assign dcl_c = (d_c < DMIN) ? DMIN : ((d_c > DMAX) ? DMAX : d_c);
  assign dint_c = dcl_c[AW+7:8];
  assign dfrac_c = dcl_c[7:0];
  assign diff_c = {2'b00, wi_q} - {2'b00, dint_c} - (AW+2)'(dfrac_c != 8'd0);
  assign cur_c = diff_c[AW+1] ? AW'(diff_c + (AW+2)'(DELAY_DEPTH)) : diff_c[AW-1:0];
  assign frac_c = (dfrac_c == 8'd0) ? 8'd0 : 8'(9'd256 - {1'b0, dfrac_c});
  assign nxt_c = (cur_q == AW'(DELAY_DEPTH - 1)) ? '0 : cur_q + 1'b1;
  assign raddr_c = (state_q == S_DLY) ? cur_c : nxt_c;
  assign ok_c = (cnt_q > {1'b0, (state_q == S_RD) ? cur_q : nxt_c});
  assign tap_c = m_q[23:8];
  assign wi_next = (wi_q == AW'(DELAY_DEPTH - 1)) ? '0 : wi_q + 1'b1;
  assign we_c = (state_q == S_WR);
  assign wdata_c = sat16(25'(x_q) + 25'(fb_q));
  assign out_load = (state_q == S_OUT) && (!out_vld_q || out_ready_i);
  assign pop_o = (state_q == S_IDLE) && head_i.valid;

  mdc_ram #(
    .WIDTH(16),
    .DEPTH(DELAY_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we_c),
    .waddr_i(wi_q),
    .wdata_i(wdata_c),
    .raddr_i(raddr_c),
    .rdata_o(rdata_c)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    acc = 1'b0;
    case (state_q)
      S_WR: begin
        mul_a = {{6{sine_c[15]}}, sine_c};
        mul_b = {1'b0, depth_c};
      end
      S_OFF: begin
        mul_a = {2'b00, cfg_i.delay_span};
        mul_b = {1'b0, off_c};
      end
      S_M0: begin
        mul_a = {{6{old_q[15]}}, old_q};
        mul_b = {9'd0, 9'd256 - {1'b0, frac_q}};
      end
      S_M1: begin
        mul_a = {{6{new_q[15]}}, new_q};
        mul_b = {10'd0, frac_q};
        acc = 1'b1;
      end
      S_TAP: begin
        mul_a = {{6{tap_c[15]}}, tap_c};
        mul_b = {3'd0, fbg_c};
      end
      S_FB: begin
        mul_a = {{6{x_q[15]}}, x_q};
        mul_b = {1'b0, 17'd32768 - wet_c};
      end
      S_MIX: begin
        mul_a = {{6{tap_q[15]}}, tap_q};
        mul_b = {1'b0, wet_c};
        acc = 1'b1;
      end
      S_OUT: begin
        acc = 1'b1;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    m_d = (acc ? m_q : 40'sd0) + mul_a * mul_b;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (head_i.valid) state_d = S_WR;
      S_WR:   state_d = S_OFF;
      S_OFF:  state_d = S_DLY;
      S_DLY:  state_d = S_RD;
      S_RD:   state_d = S_M0;
      S_M0:   state_d = S_M1;
      S_M1:   state_d = S_TAP;
      S_TAP:  state_d = S_FB;
      S_FB:   state_d = S_MIX;
      S_MIX:  state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
    if (pop_o) x_q <= head_i.sample;
    if (state_q == S_DLY) begin
      cur_q <= cur_c;
      frac_q <= frac_c;
    end
    if (state_q == S_RD) old_q <= ok_c ? rdata_c : 16'sd0;
    if (state_q == S_M0) new_q <= ok_c ? rdata_c : 16'sd0;
    if (state_q == S_TAP) tap_q <= tap_c;
    if (out_load) out_q <= sat16(m_q[39:15]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= '0;
      wi_q <= '0;
      cnt_q <= '0;
      fb_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (we_c) begin
        phase_q <= phase_q + {8'd0, cfg_i.phase_step};
        wi_q <= wi_next;
        if (cnt_q != CW'(DELAY_DEPTH)) cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == S_FB) fb_q <= sat16(m_q[39:15]);
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign sample_out_o = out_q;

  `MDC_ASSERT_NOW(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CW'(DELAY_DEPTH), "fill count overflow")
  `MDC_ASSERT_NEXT(a_wi_moves, clk_i, rst_ni, state_q == S_WR, wi_q != $past(wi_q), "write index stuck")
  `MDC_ASSERT_NEXT(a_out_done, clk_i, rst_ni, out_load, out_vld_q && state_q == S_IDLE, "result not posted")
  `MDC_ASSERT_NOW(a_pop_idle, clk_i, rst_ni, pop_o, state_q == S_IDLE && head_i.valid, "pop outside idle")

endmodule

FILE: rtl/core/modulated_delay_chorus.sv
// Top level of the modulated delay chorus: config registers, input queue and engine.
// Depends on mdc_pkg, mdc_queue and mdc_engine.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------
//  input    | in_valid_i / in_ready_o   | sample_in_i   16 bit signed
//  output   | out_valid_o / out_ready_i | sample_out_o  16 bit signed
//  config   | cfg_we_i                  | cfg_idx_i 3 bit, cfg_data_i 24 bit
//
// Each beat walks the engine states in order on the single shared multiplier, then waits on the output.
// The two-entry input queue keeps accepting while the engine and output register are busy, until full.
// Reset clears LFO phase, write index, fill count and feedback; delay memory needs no sweep.
// Taps at slots not yet written since reset read as zero through the fill count.
module modulated_delay_chorus
  import mdc_pkg::*;
#(
  parameter int DELAY_DEPTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] sample_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_out_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i
);

  mdc_cfg_t  cfg_q;
  mdc_beat_t head;
  logic      pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_step <= 24'd447392;
      cfg_q.depth_gain <= 16'd27853;
      cfg_q.feedback_gain <= 15'd3277;
      cfg_q.wet_mix <= 16'd16384;
      cfg_q.min_delay <= 20'd61440;
      cfg_q.delay_span <= 20'd307200;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PHASE_STEP: cfg_q.phase_step <= cfg_data_i;
        CFG_DEPTH_GAIN: cfg_q.depth_gain <= cfg_data_i[15:0];
        CFG_FB_GAIN:    cfg_q.feedback_gain <= cfg_data_i[14:0];
        CFG_WET_MIX:    cfg_q.wet_mix <= cfg_data_i[15:0];
        CFG_MIN_DELAY:  cfg_q.min_delay <= cfg_data_i[19:0];
        CFG_DELAY_SPAN: cfg_q.delay_span <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  mdc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_in_i(sample_in_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  mdc_engine #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_out_o(sample_out_o)
  );

endmodule

FILE: tb/modulated_delay_chorus_tb.sv
// Testbench for modulated_delay_chorus: a bit-exact predictor of the chorus
// checks every output beat. Depends on mdc_pkg and the RTL top level only.
`timescale 1ns / 1ps

module modulated_delay_chorus_tb;
  import mdc_pkg::*;

  localparam int MEM_DEPTH = 4096;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 30;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] sample_in_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] sample_out_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [23:0]        cfg_data_i = '0;

  modulated_delay_chorus dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  longint             sine_q15 [SINE_ENTRIES];
  longint             delay_line [MEM_DEPTH];
  int unsigned        write_pos;
  logic [31:0]        lfo_phase;
  longint             fb_sample;
  mdc_cfg_t           cfg;
  logic signed [15:0] expected_out [$];

  int send_idle_pct;
  int recv_idle_pct;
  int failures;
  int quiet_cycles;

  function automatic longint clip16(longint v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic void build_sine();
    longint unsigned x, x2, term;
    longint          acc;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      x = (64'd1686629713 * longint'(2 * k + 1)) / longint'(2 * SINE_ENTRIES);
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 5; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        acc = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      acc = longint'((longint'(acc) * 32767 + (64'd1 << 29)) >> 30);
      sine_q15[k] = (acc > 32767) ? 32767 : acc;
    end
  endfunction

  function automatic logic signed [15:0] chorus_predict(logic signed [15:0] x_in);
    longint xs, depth, wet, fb, sv, lfo, d, tap, mix;
    int     idx, dint, dfrac, frac, cur, nxt;
    xs = x_in;
    depth = (cfg.depth_gain > 32768) ? 32768 : cfg.depth_gain;
    wet = (cfg.wet_mix > 32768) ? 32768 : cfg.wet_mix;
    fb = (cfg.feedback_gain > 32112) ? 32112 : cfg.feedback_gain;
    delay_line[write_pos] = clip16(xs + fb_sample);
    write_pos = (write_pos + 1) % MEM_DEPTH;
    idx = lfo_phase[29:22];
    if (lfo_phase[30]) idx = SINE_ENTRIES - 1 - idx;
    sv = lfo_phase[31] ? -sine_q15[idx] : sine_q15[idx];
    lfo = (sv * depth) >>> 15;
    lfo_phase = lfo_phase + 32'(cfg.phase_step);
    d = longint'(cfg.min_delay) + (((lfo + 32768) * longint'(cfg.delay_span)) >> 16);
    if (d < 256) d = 256;
    if (d > (MEM_DEPTH - 1) * 256) d = (MEM_DEPTH - 1) * 256;
    dint = int'(d >> 8);
    dfrac = int'(d & 255);
    if (dfrac == 0) begin
      cur = (write_pos + 2 * MEM_DEPTH - dint) % MEM_DEPTH;
      frac = 0;
    end else begin
      cur = (write_pos + 2 * MEM_DEPTH - dint - 1) % MEM_DEPTH;
      frac = 256 - dfrac;
    end
    nxt = (cur + 1) % MEM_DEPTH;
    tap = (delay_line[cur] * (256 - frac) + delay_line[nxt] * frac) >>> 8;
    fb_sample = clip16((tap * fb) >>> 15);
    mix = (xs * (32768 - wet) + tap * wet) >>> 15;
    return 16'(clip16(mix));
  endfunction

  task automatic send_sample(input logic signed [15:0] s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    expected_out.push_back(chorus_predict(s));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_out.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CFG_PHASE_STEP: cfg.phase_step = data;
      CFG_DEPTH_GAIN: cfg.depth_gain = data[15:0];
      CFG_FB_GAIN:    cfg.feedback_gain = data[14:0];
      CFG_WET_MIX:    cfg.wet_mix = data[15:0];
      CFG_MIN_DELAY:  cfg.min_delay = data[19:0];
      CFG_DELAY_SPAN: cfg.delay_span = data[19:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return 16'($urandom_range(255)) - 16'sd128;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic randomize_regs();
    write_reg(CFG_PHASE_STEP, ($urandom_range(3) == 0) ? 24'($urandom)
                                                        : 24'($urandom_range(2000000)));
    write_reg(CFG_DEPTH_GAIN, ($urandom_range(4) == 0) ? 24'($urandom)
                                                        : 24'($urandom_range(32768)));
    write_reg(CFG_FB_GAIN, ($urandom_range(4) == 0) ? 24'($urandom)
                                                     : 24'($urandom_range(32112)));
    write_reg(CFG_WET_MIX, ($urandom_range(4) == 0) ? 24'($urandom)
                                                     : 24'($urandom_range(32768)));
    write_reg(CFG_MIN_DELAY, ($urandom_range(3) == 0) ? 24'($urandom)
                                                       : 24'($urandom_range(20000)));
    write_reg(CFG_DELAY_SPAN, ($urandom_range(3) == 0) ? 24'($urandom)
                                                        : 24'($urandom_range(60000)));
    if ($urandom_range(3) == 0) write_reg(3'($urandom_range(7, 6)), 24'($urandom));
  endtask

  task automatic test_reset_defaults();
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    drain();
  endtask

  task automatic test_extreme_regs();
    write_reg(CFG_DEPTH_GAIN, 24'hffff);
    write_reg(CFG_WET_MIX, 24'hffff);
    write_reg(CFG_FB_GAIN, 24'hffffff);
    write_reg(CFG_PHASE_STEP, 24'hffffff);
    write_reg(CFG_MIN_DELAY, 24'd0);
    write_reg(CFG_DELAY_SPAN, 24'd0);
    write_reg(3'd6, 24'd0);
    write_reg(3'd7, 24'hffffff);
    repeat (4) send_sample(16'sh7fff);
    repeat (4) send_sample(-16'sh8000);
    drain();
    write_reg(CFG_MIN_DELAY, 24'hffffff);
    write_reg(CFG_DELAY_SPAN, 24'hfffff);
    write_reg(CFG_PHASE_STEP, 24'd0);
    write_reg(CFG_WET_MIX, 24'd0);
    write_reg(CFG_FB_GAIN, 24'd32112);
    repeat (3) send_sample(16'sh7fff);
    drain();
    write_reg(CFG_WET_MIX, 24'd32768);
    write_reg(CFG_DEPTH_GAIN, 24'd0);
    write_reg(CFG_MIN_DELAY, 24'd384);
    repeat (3) send_sample(-16'sh8000);
    drain();
  endtask

  task automatic test_random_stream(input int sidle, input int ridle);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int blk = 0; blk < 4; blk++) begin
      randomize_regs();
      repeat (145) send_sample(random_sample());
      drain();
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_out.size() == 0) begin
        $error("sample_out: unexpected beat, actual %0d", sample_out_o);
        failures++;
      end else begin
        if (sample_out_o !== expected_out[0]) begin
          $error("sample_out: expected %0d actual %0d", expected_out[0], sample_out_o);
          failures++;
        end
        void'(expected_out.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    failures = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    build_sine();
    foreach (delay_line[i]) delay_line[i] = 0;
    write_pos = 0;
    lfo_phase = '0;
    fb_sample = 0;
    cfg.phase_step = 24'd447392;
    cfg.depth_gain = 16'd27853;
    cfg.feedback_gain = 15'd3277;
    cfg.wet_mix = 16'd16384;
    cfg.min_delay = 20'd61440;
    cfg.delay_span = 20'd307200;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_extreme_regs();
    test_random_stream(17, 58);
    test_random_stream(58, 17);
    test_random_stream(0, 0);
    if (failures == 0 && expected_out.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: modulated_delay_chorus.f
+incdir+rtl/core
rtl/core/mdc_pkg.sv
rtl/core/mdc_ram.sv
rtl/core/mdc_queue.sv
rtl/core/mdc_engine.sv
rtl/core/modulated_delay_chorus.sv
tb/modulated_delay_chorus_tb.sv
